[rtl/cht_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants of the chained hash table engine.
// Used by the channel interfaces, the modulo unit and the top level.
package cht_pkg;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  localparam int NUM_BUCKETS_DEF = 128;
  localparam int WAYS_DEF        = 8;

  localparam logic [COUNT_W-1:0] BUCKET_COUNT_RST = 8'd100;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_PUT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  // The key is reduced modulo the bucket count several bits per cycle.
  localparam int MOD_DIVIDEND_W = 32;
  localparam int MOD_BITS_STEP  = 8;
  localparam int MOD_STEPS      = MOD_DIVIDEND_W / MOD_BITS_STEP;
  localparam int MOD_CNT_W      = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/cht_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the chained hash table engine.
// Depends on cht_pkg for field widths.
interface cht_req_if;
  logic                         valid;
  logic                         ready;
  logic [cht_pkg::KIND_W-1:0]   kind;
  logic [cht_pkg::KEY_W-1:0]    key;
  logic signed [cht_pkg::VAL_W-1:0] value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface cht_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [cht_pkg::STATUS_W-1:0]     status;
  logic signed [cht_pkg::VAL_W-1:0] found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink   (input valid, input status, input found_value, output ready);
endinterface

interface cht_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cht_pkg::COUNT_W-1:0] bucket_count;

  modport source (output valid, output bucket_count, input ready);
  modport sink   (input valid, input bucket_count, output ready);
endinterface

[rtl/cht_mod_unit.sv]
`timescale 1ns / 1ps
// Iterative key modulo bucket count, eight dividend bits per cycle.
// Depends on cht_pkg for widths and step counts.
module cht_mod_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cht_pkg::KEY_W-1:0]    key,
  input  logic [cht_pkg::COUNT_W-1:0]  divisor,
  output logic                         done,
  output logic [cht_pkg::COUNT_W-1:0]  rem
);

  logic                                 busy;
  logic [cht_pkg::MOD_CNT_W-1:0]        cnt;
  logic [cht_pkg::MOD_DIVIDEND_W-1:0]   dividend;
  logic [cht_pkg::COUNT_W-1:0]          dsr;
  logic [cht_pkg::COUNT_W-1:0]          rem_next;

  // Restoring division steps: the partial remainder stays below the divisor.
  always_comb begin
    logic [cht_pkg::COUNT_W:0] t;
    rem_next = rem;
    for (int i = 0; i < cht_pkg::MOD_BITS_STEP; i++) begin
      t = {rem_next, dividend[cht_pkg::MOD_DIVIDEND_W-1-i]};
      if (t >= {1'b0, dsr}) begin
        t = t - {1'b0, dsr};
      end
      rem_next = t[cht_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == cht_pkg::MOD_CNT_W'(cht_pkg::MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= cht_pkg::MOD_DIVIDEND_W'(key);
      dsr      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      dividend <= dividend << cht_pkg::MOD_BITS_STEP;
      rem      <= rem_next;
    end
  end

endmodule

[rtl/cht_row_ram.sv]
`timescale 1ns / 1ps
// Bucket row memory: one write port, one read port with registered read data.
// Self-contained; widths come from the instantiating module.
module cht_row_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int ROW_W = 512
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ROW_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [ROW_W-1:0] rd_data
);

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/chained_hash_table_engine.sv]
`timescale 1ns / 1ps
// Chained hash table engine: put, get and delete on a bucketed key/value table.
// req carries kind, key and value; rsp returns one word per request with status
// (ok, not found, bucket full) and found_value (the stored value on a hit get,
// zero otherwise). cfg writes bucket_count, the divisor of the key hash; a count
// of zero acts as one and a count above NUM_BUCKETS acts as NUM_BUCKETS.
// One request is in flight at a time. A request passes from acceptance to its
// response word through the modulo unit (eight key bits per cycle), then a row
// read, a key compare over all ways, and the row write-back if the row changes.
// The next request is accepted in the cycle after the response is loaded.
// After reset the engine sweeps all NUM_BUCKETS rows of the row memory, one row
// per cycle, with req.ready low; cfg writes are taken throughout.
// bucket_count resets to 100.
// The response sits in an output register; while the receiver stalls the next
// request is still accepted and processed, and waits only to load its response.
// Depends on cht_pkg, the channel interfaces, cht_mod_unit and cht_row_ram.
module chained_hash_table_engine #(
  parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEF,
  parameter int WAYS        = cht_pkg::WAYS_DEF
) (
  input logic    clk,
  input logic    rst,
  cht_cfg_if.sink   cfg,
  cht_req_if.sink   req,
  cht_rsp_if.source rsp
);

  localparam int AW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = WAYS * cht_pkg::ENTRY_W;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_HASH   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_MATCH  = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [cht_pkg::COUNT_W-1:0]  bucket_count;
  logic [cht_pkg::COUNT_W-1:0]  n_eff;
  logic [cht_pkg::KIND_W-1:0]   kind;
  logic [cht_pkg::KEY_W-1:0]    key;
  logic [cht_pkg::VAL_W-1:0]    value;
  logic [AW-1:0]                bucket;
  logic [AW-1:0]                clr_addr;
  logic                         accept;
  logic                         mod_done;
  logic [cht_pkg::COUNT_W-1:0]  mod_rem;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [ROW_W-1:0]             wr_data;
  logic                         rd_en;
  logic [ROW_W-1:0]             rd_data;

  cht_pkg::entry_t [WAYS-1:0]   row;
  cht_pkg::entry_t [WAYS-1:0]   row_new;
  logic [WAYS-1:0]              hit_vec;
  logic [WAYS-1:0]              free_vec;
  logic                         row_wr;
  logic [cht_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [cht_pkg::VAL_W-1:0]    res_value, res_value_next;

  logic                         rsp_valid;
  logic [cht_pkg::STATUS_W-1:0] rsp_status;
  logic [cht_pkg::VAL_W-1:0]    rsp_value;
  logic                         rsp_load;

  assign cfg.ready       = 1'b1;
  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.found_value = rsp_value;
  assign rsp_load        = (state == S_DONE) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= cht_pkg::BUCKET_COUNT_RST;
    end else if (cfg.valid && cfg.ready) begin
      bucket_count <= cfg.bucket_count;
    end
  end

  always_comb begin
    if (bucket_count == '0) begin
      n_eff = cht_pkg::COUNT_W'(1);
    end else if (32'(bucket_count) > NUM_BUCKETS) begin
      n_eff = cht_pkg::COUNT_W'(NUM_BUCKETS);
    end else begin
      n_eff = bucket_count;
    end
  end

  cht_mod_unit u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .key     (req.key),
    .divisor (n_eff),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  cht_row_ram #(
    .DEPTH (NUM_BUCKETS),
    .AW    (AW),
    .ROW_W (ROW_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (AW'(mod_rem)),
    .rd_data (rd_data)
  );

  assign rd_en = (state == S_HASH) && mod_done;
  assign row   = rd_data;

  // The clearing sweep and the request write-back share the write port.
  always_comb begin
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = (state == S_DECIDE) && row_wr;
      wr_addr = bucket;
      wr_data = row_new;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(NUM_BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          state_next = S_READ;
        end
      end
      S_READ:   state_next = S_MATCH;
      S_MATCH:  state_next = S_DECIDE;
      S_DECIDE: state_next = S_DONE;
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= req.kind;
      key   <= req.key;
      value <= req.value;
    end
    if (rd_en) begin
      bucket <= AW'(mod_rem);
    end
  end

  // Compare the key against every way of the row read back from memory.
  always_ff @(posedge clk) begin
    if (state == S_MATCH) begin
      for (int w = 0; w < WAYS; w++) begin
        hit_vec[w]  <= row[w].valid && (row[w].key == key);
        free_vec[w] <= !row[w].valid;
      end
    end
  end

  always_comb begin
    logic [WW-1:0] hit_way;
    logic [WW-1:0] free_way;
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WW'(w);
      end
      if (free_vec[w]) begin
        free_way = WW'(w);
      end
    end

    row_new         = row;
    row_wr          = 1'b0;
    res_status_next = cht_pkg::STATUS_NOT_FOUND;
    res_value_next  = '0;
    case (kind)
      cht_pkg::KIND_PUT: begin
        if (|hit_vec) begin
          row_new[hit_way].value = value;
          row_wr                 = 1'b1;
          res_status_next        = cht_pkg::STATUS_OK;
        end else if (|free_vec) begin
          row_new[free_way].valid = 1'b1;
          row_new[free_way].key   = key;
          row_new[free_way].value = value;
          row_wr                  = 1'b1;
          res_status_next         = cht_pkg::STATUS_OK;
        end else begin
          res_status_next = cht_pkg::STATUS_FULL;
        end
      end
      cht_pkg::KIND_GET: begin
        if (|hit_vec) begin
          res_value_next  = row[hit_way].value;
          res_status_next = cht_pkg::STATUS_OK;
        end
      end
      cht_pkg::KIND_DEL: begin
        if (|hit_vec) begin
          row_new[hit_way].valid = 1'b0;
          row_wr                 = 1'b1;
          res_status_next        = cht_pkg::STATUS_OK;
        end
      end
      default: begin
        res_status_next = cht_pkg::STATUS_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      res_status <= res_status_next;
      res_value  <= res_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_status <= res_status;
      rsp_value  <= res_value;
    end
  end

endmodule
